/* hw/rtl/qcsc_pkg.sv */
// Shared types, widths, register codes and helpers for the quad corner check.
`default_nettype none
package qcsc_pkg;

  localparam int CoordW   = 16;
  localparam int FracBits = 4;
  localparam int DistW    = 12;
  localparam int CosW     = 16;
  localparam int DataW    = 32;
  localparam int AddrW    = 3;

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int MagW  = ProdW - 1;
  localparam int DotW  = ProdW + 1;
  localparam int DdW   = 2 * MagW;
  localparam int AlW   = MagW + CosW;
  localparam int BLoW  = DiffW;
  localparam int BHiW  = MagW - BLoW;
  localparam int LoW   = AlW + BLoW;
  localparam int HiW   = AlW + BHiW;
  localparam int RhsW  = AlW + MagW;
  localparam int LimW  = DistW + FracBits;
  localparam int Lim2W = 2 * LimW;
  localparam int CmpW  = (MagW > Lim2W) ? MagW : Lim2W;
  localparam int Lat   = 6;

  localparam logic RegMinDist = 1'b0;
  localparam logic RegCosLim  = 1'b1;

  localparam int MinDistRstInt = 20;
  localparam int LimRstInt     = MinDistRstInt * (2 ** FracBits);
  localparam logic [DistW-1:0] MinDistRst = DistW'(MinDistRstInt);
  localparam logic [CosW-1:0]  CosLimRst  = CosW'(49152);
  localparam logic [Lim2W-1:0] Lim2Rst    = Lim2W'(LimRstInt * LimRstInt);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  function automatic diff_t sub(input coord_t a, input coord_t b);
    return DiffW'(a) - DiffW'(b);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/qcsc_angle_lane.sv */
// Angle lane: squared-cosine test at one corner, six register stages.
`default_nettype none
module qcsc_angle_lane (
  input  wire                       clk_i,
  input  wire                       en_i,
  input  qcsc_pkg::point_t          prev_i,
  input  qcsc_pkg::point_t          corner_i,
  input  qcsc_pkg::point_t          next_i,
  input  wire [qcsc_pkg::CosW-1:0]  cos_lim_i,
  output logic                      bad_o
);

  qcsc_pkg::diff_t ax_q, ay_q, bx_q, by_q;
  qcsc_pkg::prod_t axx_q, ayy_q, bxx_q, byy_q, axbx_q, ayby_q;
  logic [qcsc_pkg::MagW-1:0] a_q, b_q, d_q, b4_q;
  logic [qcsc_pkg::DdW-1:0]  dd_q, dd5_q;
  logic [qcsc_pkg::AlW-1:0]  al_q;
  logic [qcsc_pkg::LoW-1:0]  lo_q;
  logic [qcsc_pkg::HiW-1:0]  hi_q;
  logic zero_q, zero5_q;
  logic signed [qcsc_pkg::DotW-1:0] dot;
  logic [qcsc_pkg::DotW-1:0] dmag;
  logic [qcsc_pkg::RhsW-1:0] rhs, lhs;

  always_comb begin
    dot  = qcsc_pkg::DotW'(axbx_q) + qcsc_pkg::DotW'(ayby_q);
    dmag = dot[qcsc_pkg::DotW-1] ? qcsc_pkg::DotW'(-dot) : qcsc_pkg::DotW'(dot);
    rhs  = {hi_q, {qcsc_pkg::BLoW{1'b0}}} + qcsc_pkg::RhsW'(lo_q);
    lhs  = {dd5_q, {qcsc_pkg::CosW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= qcsc_pkg::sub(next_i.x, corner_i.x);
      ay_q    <= qcsc_pkg::sub(next_i.y, corner_i.y);
      bx_q    <= qcsc_pkg::sub(prev_i.x, corner_i.x);
      by_q    <= qcsc_pkg::sub(prev_i.y, corner_i.y);
      axx_q   <= ax_q * ax_q;
      ayy_q   <= ay_q * ay_q;
      bxx_q   <= bx_q * bx_q;
      byy_q   <= by_q * by_q;
      axbx_q  <= ax_q * bx_q;
      ayby_q  <= ay_q * by_q;
      a_q     <= axx_q[qcsc_pkg::MagW-1:0] + ayy_q[qcsc_pkg::MagW-1:0];
      b_q     <= bxx_q[qcsc_pkg::MagW-1:0] + byy_q[qcsc_pkg::MagW-1:0];
      d_q     <= dmag[qcsc_pkg::MagW-1:0];
      dd_q    <= qcsc_pkg::DdW'(d_q) * qcsc_pkg::DdW'(d_q);
      al_q    <= qcsc_pkg::AlW'(a_q) * qcsc_pkg::AlW'(cos_lim_i);
      b4_q    <= b_q;
      zero_q  <= (a_q == '0) || (b_q == '0);
      lo_q    <= qcsc_pkg::LoW'(al_q) * qcsc_pkg::LoW'(b4_q[qcsc_pkg::BLoW-1:0]);
      hi_q    <= qcsc_pkg::HiW'(al_q) * qcsc_pkg::HiW'(b4_q[qcsc_pkg::MagW-1:qcsc_pkg::BLoW]);
      dd5_q   <= dd_q;
      zero5_q <= zero_q;
      bad_o   <= !zero5_q && (lhs > rhs);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qcsc_dist_lane.sv */
// Distance lane: squared distance of one corner pair against the limit, four stages.
`default_nettype none
module qcsc_dist_lane (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  qcsc_pkg::point_t           p_i,
  input  qcsc_pkg::point_t           q_i,
  input  wire [qcsc_pkg::Lim2W-1:0]  lim2_i,
  output logic                       near_o
);

  qcsc_pkg::diff_t dx_q, dy_q;
  qcsc_pkg::prod_t dxx_q, dyy_q;
  logic [qcsc_pkg::MagW-1:0] d2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= qcsc_pkg::sub(p_i.x, q_i.x);
      dy_q   <= qcsc_pkg::sub(p_i.y, q_i.y);
      dxx_q  <= dx_q * dx_q;
      dyy_q  <= dy_q * dy_q;
      d2_q   <= dxx_q[qcsc_pkg::MagW-1:0] + dyy_q[qcsc_pkg::MagW-1:0];
      near_o <= qcsc_pkg::CmpW'(d2_q) < qcsc_pkg::CmpW'(lim2_i);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qcsc_cross_lane.sv */
// Cross lane: sign of the cross product (q-p) x (r-p), four stages.
`default_nettype none
module qcsc_cross_lane (
  input  wire               clk_i,
  input  wire               en_i,
  input  qcsc_pkg::point_t  p_i,
  input  qcsc_pkg::point_t  q_i,
  input  qcsc_pkg::point_t  r_i,
  output qcsc_pkg::sign_t   sign_o
);

  qcsc_pkg::diff_t qx_q, qy_q, rx_q, ry_q;
  qcsc_pkg::prod_t m1_q, m2_q;
  logic signed [qcsc_pkg::DotW-1:0] c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q       <= qcsc_pkg::sub(q_i.x, p_i.x);
      qy_q       <= qcsc_pkg::sub(q_i.y, p_i.y);
      rx_q       <= qcsc_pkg::sub(r_i.x, p_i.x);
      ry_q       <= qcsc_pkg::sub(r_i.y, p_i.y);
      m1_q       <= qx_q * ry_q;
      m2_q       <= qy_q * rx_q;
      c_q        <= qcsc_pkg::DotW'(m1_q) - qcsc_pkg::DotW'(m2_q);
      sign_o.pos <= !c_q[qcsc_pkg::DotW-1] && (c_q != '0);
      sign_o.neg <= c_q[qcsc_pkg::DotW-1];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/quad_corner_sanity_check_top.sv */
// Top level: register port, lanes for angle, distance and winding, merge and output word.
//
//   channel | direction | handshake                 | contents
//   in      | input     | in_valid_i / in_stall_o   | x0..y3, four corners
//   out     | output    | out_valid_o / out_stall_i | reject
//   config  | input     | APB psel/penable/pwrite   | min distance, cos^2 limit
//
// One word per cycle while the result is not stalled; the depth from accept to result is set by the
// angle lane's six-stage multiply chain plus the output register.
// Reset clears the valid pipeline and restores register defaults; no clearing pass.
// A stalled result holds in the output register; the pipeline keeps filling
// until its last stage also holds a finished word.
`default_nettype none
module quad_corner_sanity_check_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [qcsc_pkg::AddrW-1:0]    paddr,
  input  wire [qcsc_pkg::DataW-1:0]    pwdata,
  output logic [qcsc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [qcsc_pkg::CoordW-1:0]   x0_i,
  input  wire [qcsc_pkg::CoordW-1:0]   y0_i,
  input  wire [qcsc_pkg::CoordW-1:0]   x1_i,
  input  wire [qcsc_pkg::CoordW-1:0]   y1_i,
  input  wire [qcsc_pkg::CoordW-1:0]   x2_i,
  input  wire [qcsc_pkg::CoordW-1:0]   y2_i,
  input  wire [qcsc_pkg::CoordW-1:0]   x3_i,
  input  wire [qcsc_pkg::CoordW-1:0]   y3_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         reject_o
);

  logic [qcsc_pkg::DistW-1:0] mcd_q;
  logic [qcsc_pkg::CosW-1:0]  csl_q;
  logic [qcsc_pkg::Lim2W-1:0] lim2_q;
  logic [qcsc_pkg::LimW-1:0]  lim;
  logic                       cfg_wr;

  logic [qcsc_pkg::Lat-1:0] v_q;
  logic adv;
  logic load;

  qcsc_pkg::point_t pt [4];
  logic [1:0] ang_bad;
  logic [5:0] near;
  qcsc_pkg::sign_t c012, c123, c301;
  logic wind_bad;
  logic mid_q, mid2_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign lim    = qcsc_pkg::LimW'(mcd_q) << qcsc_pkg::FracBits;

  always_comb begin
    unique case (paddr[2])
      qcsc_pkg::RegMinDist: prdata = qcsc_pkg::DataW'(mcd_q);
      qcsc_pkg::RegCosLim:  prdata = qcsc_pkg::DataW'(csl_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcd_q  <= qcsc_pkg::MinDistRst;
      csl_q  <= qcsc_pkg::CosLimRst;
      lim2_q <= qcsc_pkg::Lim2Rst;
    end else begin
      lim2_q <= qcsc_pkg::Lim2W'(lim) * qcsc_pkg::Lim2W'(lim);
      if (cfg_wr) begin
        unique case (paddr[2])
          qcsc_pkg::RegMinDist: mcd_q <= pwdata[qcsc_pkg::DistW-1:0];
          qcsc_pkg::RegCosLim:  csl_q <= pwdata[qcsc_pkg::CosW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign pt[0] = '{x: x0_i, y: y0_i};
  assign pt[1] = '{x: x1_i, y: y1_i};
  assign pt[2] = '{x: x2_i, y: y2_i};
  assign pt[3] = '{x: x3_i, y: y3_i};

  assign adv        = !(v_q[qcsc_pkg::Lat-1] && out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign load       = adv && v_q[qcsc_pkg::Lat-1];

  for (genvar k = 1; k < 3; k++) begin : g_ang
    qcsc_angle_lane u_ang (
      .clk_i     (clk_i),
      .en_i      (adv),
      .prev_i    (pt[k-1]),
      .corner_i  (pt[k]),
      .next_i    (pt[k+1]),
      .cos_lim_i (csl_q),
      .bad_o     (ang_bad[k-1])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_di
    for (genvar j = i + 1; j < 4; j++) begin : g_dj
      localparam int Idx = i * 3 - (i * (i - 1)) / 2 + (j - i - 1);
      qcsc_dist_lane u_dist (
        .clk_i  (clk_i),
        .en_i   (adv),
        .p_i    (pt[i]),
        .q_i    (pt[j]),
        .lim2_i (lim2_q),
        .near_o (near[Idx])
      );
    end
  end

  qcsc_cross_lane u_c012 (
    .clk_i (clk_i), .en_i (adv), .p_i (pt[0]), .q_i (pt[1]), .r_i (pt[2]), .sign_o (c012)
  );
  qcsc_cross_lane u_c123 (
    .clk_i (clk_i), .en_i (adv), .p_i (pt[1]), .q_i (pt[2]), .r_i (pt[3]), .sign_o (c123)
  );
  qcsc_cross_lane u_c301 (
    .clk_i (clk_i), .en_i (adv), .p_i (pt[3]), .q_i (pt[0]), .r_i (pt[1]), .sign_o (c301)
  );

  assign wind_bad = (c012.pos && c123.neg) || (c012.neg && c123.pos) ||
                    (c301.pos && c012.neg) || (c301.neg && c012.pos);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mid_q  <= (|near) || wind_bad;
      mid2_q <= mid_q;
    end
    if (load) begin
      reject_o <= mid2_q || (|ang_bad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[qcsc_pkg::Lat-2:0], in_valid_i};
      end
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/qcsc_checker.sv */
// Port-level checker for the quad corner check, bound to the top level.
`default_nettype none
module qcsc_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_stall_o,
  input wire out_valid_o,
  input wire out_stall_i,
  input wire reject_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reject_o))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word right after reset");

endmodule

bind quad_corner_sanity_check_top qcsc_checker u_qcsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .reject_o    (reject_o)
);
`default_nettype wire
